>>> rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants of the region allocator
// Payload structures, command and register codes, table control and the
// operation codes of the shared adder.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int ADDR_W    = 32;
    localparam int PAD_W     = 21;
    localparam int CMD_W     = 2;
    localparam int LIVE_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int OPND_W    = 33;
    localparam int SUM_W     = 34;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAD_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_HIGH = 2'd2;

    localparam logic [PAD_W-1:0]  PAD_RESET  = 21'd4096;
    localparam logic [ADDR_W-1:0] LOW_RESET  = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] HIGH_RESET = 32'hFFFF_F000;

    localparam int LOW_SENTINEL  = 0;
    localparam int HIGH_SENTINEL = 1;
    localparam int FIRST_FREE    = 2;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic rd_en;
        logic wr_next;
        logic wr_entry;
    } t_tbl_ctl;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] req_size;
        logic [ADDR_W-1:0] addr;
    } t_cmd_item;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_size;
        logic [LIVE_W-1:0] live_entries;
    } t_rsp_item;

endpackage

>>> rtl/ffra_if.sv
// ----------------------------------------------------------------------------
// ffra_if: valid/ready channel
// Carries one payload item per transfer from a source to a sink.
// ----------------------------------------------------------------------------
interface ffra_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator: first-fit address region allocator
// Keeps address regions in a list sorted by base address between two
// sentinels and serves allocate, free and look-up commands one at a time.
// ----------------------------------------------------------------------------
// One command is in progress at a time; the command channel is ready again
// once its response has gone to the output register, which holds it until the
// sink takes it. PAGE_BYTES must be a power of two, as the page rounding is a
// mask. After the transfer, allocate sizes the request in the rounding add,
// rounding subtract and pad steps, then fetches and tests each list entry
// visited, the entry that closes the gap that fits taking only the first
// test, then reads, writes and finishes the link of the new entry, and
// responds. Free and look-up fetch and test each entry visited; a free then
// unlinks the previous entry and the hit, and both respond. A walk visits at
// most TABLE_ENTRIES entries, one more when allocating. The steps are set by
// the single shared adder and comparator and the registered table read port.
module first_fit_region_allocator #(
    parameter int TABLE_ENTRIES = 64,
    parameter int PAGE_BYTES    = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ffra_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffra_pkg::ADDR_W-1:0]    i_cfg_data,
    ffra_if.sink                           i_cmd,
    ffra_if.source                         o_rsp
);
    import ffra_pkg::*;

    localparam int               IW      = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0]    NIL     = IW'(TABLE_ENTRIES);
    localparam logic [IW-1:0]    LAST_IX = IW'(TABLE_ENTRIES - 1);
    localparam logic [OPND_W-1:0] PAGE_M1 = OPND_W'(PAGE_BYTES - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RND_ADD,
        S_RND_SUB,
        S_RND_PAD,
        S_FETCH,
        S_TEST1,
        S_TEST2,
        S_LINK_RD,
        S_LINK_WR,
        S_LINK_FIN,
        S_UNL_PREV,
        S_UNL_HIT,
        S_RESP
    } t_state;

    t_state            r_state;
    logic [PAD_W-1:0]  r_pad;
    logic [ADDR_W-1:0] r_low;
    logic [ADDR_W-1:0] r_high;

    logic [CMD_W-1:0]  r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [OPND_W-1:0] r_v;
    logic [ADDR_W-1:0] r_sz;
    logic [OPND_W-1:0] r_prev_end;
    logic [IW-1:0]     r_cur;
    logic [IW-1:0]     r_prev;
    logic [IW-1:0]     r_k;
    logic [IW-1:0]     r_nx;
    logic              r_ge;
    logic [IW-1:0]     r_free_head;
    logic [IW-1:0]     r_count;
    logic              r_res_ok;
    logic [ADDR_W-1:0] r_res_base;
    logic [ADDR_W-1:0] r_res_size;
    logic              r_out_valid;
    t_rsp_item         r_out;

    t_alu_op           alu_op;
    logic [OPND_W-1:0] alu_x;
    logic [OPND_W-1:0] alu_y;
    logic [OPND_W-1:0] alu_z;
    logic [SUM_W-1:0]  alu_sum;
    logic              alu_le;

    t_tbl_ctl          tbl_ctl;
    logic [IW-1:0]     tbl_rd_idx;
    logic [IW-1:0]     tbl_wr_next_idx;
    logic [IW-1:0]     tbl_wr_next_val;
    logic [ADDR_W-1:0] tbl_base;
    logic [ADDR_W-1:0] tbl_size;
    logic [IW-1:0]     tbl_next;

    logic              is_alloc;

    assign is_alloc = (r_cmd == CMD_ALLOC);

    ffra_alu u_alu (
        .i_op  (alu_op),
        .i_x   (alu_x),
        .i_y   (alu_y),
        .i_z   (alu_z),
        .o_sum (alu_sum),
        .o_le  (alu_le)
    );

    ffra_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (tbl_ctl),
        .i_rd_idx      (tbl_rd_idx),
        .i_wr_next_idx (tbl_wr_next_idx),
        .i_wr_next_val (tbl_wr_next_val),
        .i_wr_ent_idx  (r_free_head),
        .i_wr_base     (r_prev_end[ADDR_W-1:0]),
        .i_wr_size     (r_sz),
        .i_low_base    (r_low),
        .i_high_base   (r_high),
        .o_base        (tbl_base),
        .o_size        (tbl_size),
        .o_next        (tbl_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad  <= PAD_RESET;
            r_low  <= LOW_RESET;
            r_high <= HIGH_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PAD_BYTES:   r_pad  <= i_cfg_data[PAD_W-1:0];
                CFG_REGION_LOW:  r_low  <= i_cfg_data;
                CFG_REGION_HIGH: r_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        alu_op          = ALU_ADD;
        alu_x           = '0;
        alu_y           = '0;
        alu_z           = '0;
        tbl_ctl         = '0;
        tbl_rd_idx      = r_cur;
        tbl_wr_next_idx = r_prev;
        tbl_wr_next_val = r_nx;
        unique case (r_state)
            S_RND_ADD: begin
                alu_x = r_v;
                alu_y = PAGE_M1;
            end
            S_RND_SUB: begin
                alu_op = ALU_SUB;
                alu_x  = r_v;
                alu_y  = r_v & PAGE_M1;
            end
            S_RND_PAD: begin
                alu_x = r_v;
                alu_y = OPND_W'(r_pad);
                alu_z = OPND_W'({ADDR_W{1'b1}});
            end
            S_FETCH: begin
                tbl_ctl.rd_en = 1'b1;
            end
            S_TEST1: begin
                if (is_alloc) begin
                    alu_x = r_prev_end;
                    alu_y = {1'b0, r_sz};
                    alu_z = {1'b0, tbl_base};
                end else begin
                    alu_x = {1'b0, tbl_base};
                    alu_z = {1'b0, r_addr};
                end
            end
            S_TEST2: begin
                alu_x = {1'b0, tbl_base};
                alu_y = {1'b0, tbl_size};
                alu_z = {1'b0, r_addr};
            end
            S_LINK_RD: begin
                tbl_ctl.rd_en = 1'b1;
                tbl_rd_idx    = r_free_head;
            end
            S_LINK_WR: begin
                tbl_ctl.wr_next  = 1'b1;
                tbl_ctl.wr_entry = 1'b1;
                tbl_wr_next_val  = r_free_head;
            end
            S_LINK_FIN: begin
                tbl_ctl.wr_next = 1'b1;
                tbl_wr_next_idx = r_free_head;
                tbl_wr_next_val = r_cur;
            end
            S_UNL_PREV: begin
                tbl_ctl.wr_next = 1'b1;
            end
            S_UNL_HIT: begin
                tbl_ctl.wr_next = 1'b1;
                tbl_wr_next_idx = r_cur;
                tbl_wr_next_val = r_free_head;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_free_head <= IW'(FIRST_FREE);
            r_count     <= IW'(FIRST_FREE);
        end else begin
            if (r_out_valid && o_rsp.ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd      <= i_cmd.data.cmd;
                        r_addr     <= i_cmd.data.addr;
                        r_v        <= {1'b0, i_cmd.data.req_size};
                        r_cur      <= IW'(LOW_SENTINEL);
                        r_prev     <= IW'(LOW_SENTINEL);
                        r_k        <= '0;
                        r_res_ok   <= 1'b0;
                        r_res_base <= '0;
                        r_res_size <= '0;
                        case (i_cmd.data.cmd) inside
                            CMD_ALLOC:            r_state <= S_RND_ADD;
                            CMD_FREE, CMD_LOOKUP: r_state <= S_FETCH;
                            default:              r_state <= S_RESP;
                        endcase
                    end
                end
                S_RND_ADD: begin
                    r_v     <= alu_sum[OPND_W-1:0];
                    r_state <= S_RND_SUB;
                end
                S_RND_SUB: begin
                    r_v     <= alu_sum[OPND_W-1:0];
                    r_state <= S_RND_PAD;
                end
                S_RND_PAD: begin
                    r_sz <= alu_sum[ADDR_W-1:0];
                    if (alu_le && (r_free_head != NIL)) begin
                        r_state <= S_FETCH;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_FETCH: begin
                    r_state <= S_TEST1;
                end
                S_TEST1: begin
                    if (is_alloc) begin
                        if ((r_k != '0) && alu_le) begin
                            r_state <= S_LINK_RD;
                        end else begin
                            r_state <= S_TEST2;
                        end
                    end else begin
                        r_ge    <= alu_le;
                        r_state <= S_TEST2;
                    end
                end
                S_TEST2: begin
                    if (is_alloc) begin
                        r_prev_end <= alu_sum[OPND_W-1:0];
                        if ((tbl_next != NIL) && (r_k < NIL)) begin
                            r_prev  <= r_cur;
                            r_cur   <= tbl_next;
                            r_k     <= r_k + IW'(1);
                            r_state <= S_FETCH;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end else if (r_ge && !alu_le) begin
                        r_res_ok   <= 1'b1;
                        r_res_base <= tbl_base;
                        r_res_size <= tbl_size;
                        r_nx       <= tbl_next;
                        r_state    <= (r_cmd == CMD_FREE) ? S_UNL_PREV : S_RESP;
                    end else if ((tbl_next != NIL) && (r_k < LAST_IX)) begin
                        r_prev  <= r_cur;
                        r_cur   <= tbl_next;
                        r_k     <= r_k + IW'(1);
                        r_state <= S_FETCH;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_LINK_RD: begin
                    r_state <= S_LINK_WR;
                end
                S_LINK_WR: begin
                    r_res_ok   <= 1'b1;
                    r_res_base <= r_prev_end[ADDR_W-1:0];
                    r_res_size <= r_sz;
                    r_state    <= S_LINK_FIN;
                end
                S_LINK_FIN: begin
                    r_free_head <= tbl_next;
                    r_count     <= r_count + IW'(1);
                    r_state     <= S_RESP;
                end
                S_UNL_PREV: begin
                    r_state <= S_UNL_HIT;
                end
                S_UNL_HIT: begin
                    r_free_head <= r_cur;
                    if (r_count != '0) begin
                        r_count <= r_count - IW'(1);
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid        <= 1'b1;
                        r_out.ok           <= r_res_ok;
                        r_out.region_base  <= r_res_base;
                        r_out.region_size  <= r_res_size;
                        r_out.live_entries <= LIVE_W'(r_count);
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

`ifndef SYNTHESIS
    a_free_not_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UNL_PREV) |-> (r_k != '0))
        else $error("free unlinks the head of the list");

    a_link_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK_RD) |-> (r_free_head != NIL))
        else $error("link started with an empty free chain");

    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.data.ok) |->
            ((o_rsp.data.region_base == '0) && (o_rsp.data.region_size == '0)))
        else $error("failed response carries a region");

    a_count_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (($past(r_state) == S_LINK_FIN) || ($past(r_state) == S_UNL_HIT)))
        else $error("entry count changed outside link or unlink");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK_FIN) |-> (r_count < NIL))
        else $error("entry count would exceed the table");
`endif

endmodule

>>> rtl/ffra_alu.sv
// ----------------------------------------------------------------------------
// ffra_alu: shared adder and comparator
// Adds two 33-bit operands without wrap, or subtracts them, and compares the
// sum against a third operand. The sequencer's rounding, pad and tests use it.
// ----------------------------------------------------------------------------
module ffra_alu (
    input  ffra_pkg::t_alu_op            i_op,
    input  logic [ffra_pkg::OPND_W-1:0]  i_x,
    input  logic [ffra_pkg::OPND_W-1:0]  i_y,
    input  logic [ffra_pkg::OPND_W-1:0]  i_z,
    output logic [ffra_pkg::SUM_W-1:0]   o_sum,
    output logic                         o_le
);
    import ffra_pkg::*;

    logic             sub;
    logic [SUM_W-1:0] y_ext;

    assign sub   = (i_op == ALU_SUB);
    assign y_ext = sub ? ~{1'b0, i_y} : {1'b0, i_y};
    assign o_sum = {1'b0, i_x} + y_ext + SUM_W'(sub);
    assign o_le  = (o_sum <= {1'b0, i_z});

endmodule

>>> rtl/ffra_table.sv
// ----------------------------------------------------------------------------
// ffra_table: region table storage
// Base, size and link memories with one registered read port and one write
// port each. Sentinel entries read from the boundary registers, and links
// at or above the fill mark read as their reset chain.
// ----------------------------------------------------------------------------
module ffra_table #(
    parameter  int TABLE_ENTRIES = 64,
    localparam int IW = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffra_pkg::t_tbl_ctl          i_ctl,
    input  logic [IW-1:0]               i_rd_idx,
    input  logic [IW-1:0]               i_wr_next_idx,
    input  logic [IW-1:0]               i_wr_next_val,
    input  logic [IW-1:0]               i_wr_ent_idx,
    input  logic [ffra_pkg::ADDR_W-1:0] i_wr_base,
    input  logic [ffra_pkg::ADDR_W-1:0] i_wr_size,
    input  logic [ffra_pkg::ADDR_W-1:0] i_low_base,
    input  logic [ffra_pkg::ADDR_W-1:0] i_high_base,
    output logic [ffra_pkg::ADDR_W-1:0] o_base,
    output logic [ffra_pkg::ADDR_W-1:0] o_size,
    output logic [IW-1:0]               o_next
);
    import ffra_pkg::*;

    localparam int            AW  = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] NIL = IW'(TABLE_ENTRIES);

    logic [ADDR_W-1:0] r_base_mem [TABLE_ENTRIES];
    logic [ADDR_W-1:0] r_size_mem [TABLE_ENTRIES];
    logic [IW-1:0]     r_next_mem [TABLE_ENTRIES];

    logic [ADDR_W-1:0] r_rd_base;
    logic [ADDR_W-1:0] r_rd_size;
    logic [IW-1:0]     r_rd_next;
    logic [IW-1:0]     r_rd_idx;
    logic              r_rd_low;
    logic              r_rd_high;
    logic              r_rd_fresh;
    logic [IW-1:0]     r_fill;
    logic [IW-1:0]     r_next0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_entry) begin
            r_base_mem[i_wr_ent_idx[AW-1:0]] <= i_wr_base;
            r_size_mem[i_wr_ent_idx[AW-1:0]] <= i_wr_size;
        end
        if (i_ctl.wr_next) begin
            r_next_mem[i_wr_next_idx[AW-1:0]] <= i_wr_next_val;
        end
        if (i_ctl.rd_en) begin
            r_rd_base  <= r_base_mem[i_rd_idx[AW-1:0]];
            r_rd_size  <= r_size_mem[i_rd_idx[AW-1:0]];
            r_rd_next  <= r_next_mem[i_rd_idx[AW-1:0]];
            r_rd_idx   <= i_rd_idx;
            r_rd_low   <= (i_rd_idx == IW'(LOW_SENTINEL));
            r_rd_high  <= (i_rd_idx == IW'(HIGH_SENTINEL));
            r_rd_fresh <= (i_rd_idx >= r_fill);
        end
    end

    // Entries at or above the fill mark have never been linked, so they read
    // as the free chain set up at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= IW'(FIRST_FREE);
            r_next0 <= IW'(HIGH_SENTINEL);
        end else if (i_ctl.wr_next) begin
            if (i_wr_next_idx >= r_fill) begin
                r_fill <= i_wr_next_idx + IW'(1);
            end
            if (i_wr_next_idx == IW'(LOW_SENTINEL)) begin
                r_next0 <= i_wr_next_val;
            end
        end
    end

    always_comb begin
        if (r_rd_low) begin
            o_base = i_low_base;
            o_size = '0;
            o_next = r_next0;
        end else if (r_rd_high) begin
            o_base = i_high_base;
            o_size = '0;
            o_next = NIL;
        end else begin
            o_base = r_rd_base;
            o_size = r_rd_size;
            o_next = r_rd_fresh ? (r_rd_idx + IW'(1)) : r_rd_next;
        end
    end

endmodule

>>> tb/first_fit_region_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_test: self-checking bench of the region allocator
// A directed table, then six random phases under different pad and sentinel
// settings, drive allocate, free, look-up and unused commands over valid/ready
// channels. Each response transfer is compared field by field with its typed
// row answer or with a predictor that keeps its own copy of the region list.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_test;
    import ffra_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int PAGE_BYTES    = 4096;
    localparam int CYCLE_LIMIT   = 1_500_000;

    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [LIVE_W-1:0] END_MARK   = 7'(TABLE_ENTRIES);

    typedef enum bit {ROW_CMD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [1:0]        code;
        logic [31:0]       value;
        logic [31:0]       addr;
        bit                typed;
        bit                ok;
        logic [31:0]       base;
        logic [31:0]       size;
        logic [LIVE_W-1:0] live;
    } t_stim_row;

    typedef struct {
        logic [PAD_W-1:0] pad;
        bit               pad_random;
        logic [31:0]      low;
        logic [31:0]      high;
        int               items;
        int               alloc_pct;
        int               free_pct;
        bit               clear_first;
    } t_phase;

    typedef logic [LIVE_W-1:0] t_slot_q[$];

    // Rows that are typed hold the answer; the others are left to the predictor.
    t_stim_row directed_rows [27] = '{
        '{ROW_CMD, CMD_LOOKUP, 32'h00000000, 32'h00000000, 1, 0, 32'h0, 32'h00000000, 2},
        '{ROW_CMD, CMD_ALLOC,  32'h00000001, 32'h00000000, 1, 1, 32'h0, 32'h00002000, 3},
        '{ROW_CMD, CMD_ALLOC,  32'h00000000, 32'hFFFFFFFF, 1, 1, 32'h2000, 32'h1000, 4},
        '{ROW_CMD, CMD_LOOKUP, 32'hFFFFFFFF, 32'h00001FFF, 1, 1, 32'h0, 32'h00002000, 4},
        '{ROW_CMD, CMD_LOOKUP, 32'h00000000, 32'h00002000, 1, 1, 32'h2000, 32'h1000, 4},
        '{ROW_CMD, CMD_LOOKUP, 32'h00000000, 32'hFFFFF000, 1, 0, 32'h0, 32'h00000000, 4},
        '{ROW_CMD, CMD_LOOKUP, 32'h00000000, 32'hFFFFFFFF, 1, 0, 32'h0, 32'h00000000, 4},
        '{ROW_CMD, CMD_FREE,   32'h00000000, 32'h00002FFF, 1, 1, 32'h2000, 32'h1000, 3},
        '{ROW_CMD, CMD_ALLOC,  32'hFFFFFFFF, 32'h00000000, 1, 0, 32'h0, 32'h00000000, 3},
        '{ROW_CMD, CMD_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 32'h0, 32'h00000000, 3},
        '{ROW_CMD, CMD_FREE,   32'h00000000, 32'h00000000, 1, 1, 32'h0, 32'h00002000, 2},
        '{ROW_CMD, CMD_ALLOC,  32'hFFFFE000, 32'h00000000, 1, 1, 32'h0, 32'hFFFFF000, 3},
        '{ROW_CMD, CMD_ALLOC,  32'h00000000, 32'h00000000, 1, 0, 32'h0, 32'h00000000, 3},
        '{ROW_CMD, CMD_FREE,   32'h00000000, 32'hFFFFEFFF, 1, 1, 32'h0, 32'hFFFFF000, 2},
        '{ROW_CMD, CMD_ALLOC,  32'hFFFFE001, 32'h00000000, 1, 0, 32'h0, 32'h00000000, 2},
        '{ROW_CFG, CFG_PAD_BYTES, 32'h00000000, 32'h0, 0, 0, 32'h0, 32'h0, 0},
        '{ROW_CMD, CMD_ALLOC,  32'h00000000, 32'h00000000, 1, 1, 32'h0, 32'h00000000, 3},
        '{ROW_CMD, CMD_ALLOC,  32'h00001000, 32'h00000000, 1, 1, 32'h0, 32'h00001000, 4},
        '{ROW_CMD, CMD_LOOKUP, 32'h00000000, 32'h00000000, 1, 1, 32'h0, 32'h00001000, 4},
        '{ROW_CFG, CFG_REGION_LOW, 32'h80000000, 32'h0, 0, 0, 32'h0, 32'h0, 0},
        '{ROW_CMD, CMD_ALLOC,  32'h00000001, 32'h00000000, 1, 1, 32'h1000, 32'h1000, 5},
        '{ROW_CMD, CMD_LOOKUP, 32'h00000000, 32'h80000000, 1, 0, 32'h0, 32'h00000000, 5},
        '{ROW_CMD, CMD_FREE,   32'h00000000, 32'h00001FFF, 1, 1, 32'h1000, 32'h1000, 4},
        '{ROW_CFG, CFG_REGION_HIGH, 32'hFFFFFFFF, 32'h0, 0, 0, 32'h0, 32'h0, 0},
        '{ROW_CFG, CFG_PAD_BYTES, 32'h00100000, 32'h0, 0, 0, 32'h0, 32'h0, 0},
        '{ROW_CMD, CMD_ALLOC,  32'h00012345, 32'h00000000, 0, 0, 32'h0, 32'h00000000, 0},
        '{ROW_CMD, CMD_FREE,   32'h00000000, 32'h00001000, 0, 0, 32'h0, 32'h00000000, 0}
    };

    t_phase phases [6] = '{
        '{21'h001000, 0, 32'h00000000, 32'hFFFFF000, 170, 65, 15, 0},
        '{21'h000000, 0, 32'h00000000, 32'h00040000, 120, 50, 30, 1},
        '{21'h100000, 0, 32'h00000000, 32'hFFFFF000, 170, 70, 15, 1},
        '{21'h000000, 1, 32'hC0000000, 32'h00008000, 130, 45, 35, 0},
        '{21'h0001FF, 0, 32'h00010000, 32'hFFFFFFFF, 170, 50, 30, 1},
        '{21'h001000, 0, 32'h00000000, 32'hFFFFF000, 130, 40, 40, 0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;

    ffra_if #(.T(t_cmd_item)) cmd_if ();
    ffra_if #(.T(t_rsp_item)) rsp_if ();

    first_fit_region_allocator #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_rsp      (rsp_if)
    );

    // Shadow copy of the region table.
    logic [ADDR_W-1:0] slot_base [TABLE_ENTRIES];
    logic [ADDR_W-1:0] slot_size [TABLE_ENTRIES];
    logic [LIVE_W-1:0] slot_link [TABLE_ENTRIES];
    logic [LIVE_W-1:0] chain_head;
    logic [LIVE_W-1:0] spare_head;
    logic [LIVE_W-1:0] chain_len;
    logic [PAD_W-1:0]  pad_now;

    t_rsp_item answers_due[$];
    t_rsp_item due_answer;
    int        fault_count = 0;
    int        issued_count = 0;
    int        cycle_count = 0;
    int        sender_idle_pct = 7;
    int        receiver_stall_pct = 67;

    function automatic t_rsp_item predict_answer(t_cmd_item item);
        t_rsp_item         ans;
        logic [63:0]       need;
        logic [63:0]       gap_start;
        logic [63:0]       lo;
        logic [63:0]       hi;
        logic [LIVE_W-1:0] cur;
        logic [LIVE_W-1:0] prv;
        logic [LIVE_W-1:0] nxt;
        logic [LIVE_W-1:0] slot;
        int                steps;
        bit                walking;
        ans = '0;
        steps = 0;
        cur = chain_head;
        if (item.cmd == CMD_ALLOC) begin
            need = (64'(item.req_size) + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES)
                   * 64'(PAGE_BYTES) + 64'(pad_now);
            walking = (need <= 64'hFFFF_FFFF) && (spare_head < TABLE_ENTRIES);
            while (walking && steps < TABLE_ENTRIES && cur < TABLE_ENTRIES) begin
                nxt = slot_link[cur];
                if (nxt >= TABLE_ENTRIES) begin
                    walking = 0;
                end else begin
                    gap_start = 64'(slot_base[cur]) + 64'(slot_size[cur]);
                    if (gap_start + need <= 64'(slot_base[nxt])) begin
                        slot = spare_head;
                        spare_head = slot_link[slot];
                        slot_link[slot] = nxt;
                        slot_link[cur] = slot;
                        slot_base[slot] = gap_start[31:0];
                        slot_size[slot] = need[31:0];
                        chain_len = chain_len + 1'b1;
                        ans.ok = 1'b1;
                        ans.region_base = gap_start[31:0];
                        ans.region_size = need[31:0];
                        walking = 0;
                    end
                    cur = nxt;
                    steps++;
                end
            end
        end else if (item.cmd == CMD_FREE || item.cmd == CMD_LOOKUP) begin
            prv = END_MARK;
            walking = 1;
            while (walking && steps < TABLE_ENTRIES && cur < TABLE_ENTRIES) begin
                lo = 64'(slot_base[cur]);
                hi = lo + 64'(slot_size[cur]);
                if (lo <= 64'(item.addr) && 64'(item.addr) < hi) begin
                    walking = 0;
                end else begin
                    prv = cur;
                    cur = slot_link[cur];
                    steps++;
                end
            end
            if (!walking) begin
                ans.ok = 1'b1;
                ans.region_base = slot_base[cur];
                ans.region_size = slot_size[cur];
                if (item.cmd == CMD_FREE) begin
                    if (prv < TABLE_ENTRIES) begin
                        slot_link[prv] = slot_link[cur];
                    end else begin
                        chain_head = slot_link[cur];
                    end
                    slot_link[cur] = spare_head;
                    spare_head = cur;
                    if (chain_len != 0) begin
                        chain_len = chain_len - 1'b1;
                    end
                end
            end
        end
        ans.live_entries = chain_len;
        return ans;
    endfunction

    function automatic t_slot_q sized_slots();
        t_slot_q           found;
        logic [LIVE_W-1:0] cur;
        cur = chain_head;
        for (int n = 0; n < TABLE_ENTRIES && cur < TABLE_ENTRIES; n++) begin
            if (slot_size[cur] != 0) begin
                found.push_back(cur);
            end
            cur = slot_link[cur];
        end
        return found;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
        case (index)
            CFG_PAD_BYTES:   pad_now = value[PAD_W-1:0];
            CFG_REGION_LOW:  slot_base[LOW_SENTINEL] = value;
            CFG_REGION_HIGH: slot_base[HIGH_SENTINEL] = value;
            default: ;
        endcase
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic wait_for_answers();
        while (answers_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic issue_command(input t_cmd_item item, input bit typed,
                                 input t_rsp_item typed_answer);
        t_rsp_item predicted;
        if (issued_count < 350) begin
            sender_idle_pct = 7;
            receiver_stall_pct = 67;
        end else if (issued_count < 700) begin
            sender_idle_pct = 67;
            receiver_stall_pct = 7;
        end else begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
        end
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid = 1'b1;
        cmd_if.data = item;
        @(posedge i_clk);
        while (!cmd_if.ready) begin
            @(posedge i_clk);
        end
        predicted = predict_answer(item);
        answers_due.push_back(typed ? typed_answer : predicted);
        issued_count++;
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
    endtask

    task automatic pick_command(input int alloc_pct, input int free_pct,
                                output t_cmd_item item);
        t_slot_q           sized;
        logic [LIVE_W-1:0] s;
        int                roll;
        roll = $urandom_range(99, 0);
        item.req_size = $urandom;
        item.addr = $urandom;
        if (roll < alloc_pct) begin
            item.cmd = CMD_ALLOC;
            case ($urandom_range(19, 0))
                0:       item.req_size = $urandom;
                1:       item.req_size = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
                2, 3, 4: item.req_size = $urandom_range(32'h0004_0000, 0);
                default: item.req_size = $urandom_range(32'h0000_6000, 1);
            endcase
        end else if (roll < 97) begin
            item.cmd = (roll < alloc_pct + free_pct) ? CMD_FREE : CMD_LOOKUP;
            sized = sized_slots();
            if (sized.size() != 0 && $urandom_range(9, 0) != 0) begin
                s = sized[$urandom_range(sized.size() - 1, 0)];
                case ($urandom_range(9, 0))
                    0:       item.addr = slot_base[s] + slot_size[s];
                    1:       item.addr = slot_base[s] - 1;
                    2:       item.addr = slot_base[s] + slot_size[s] - 1;
                    default: item.addr = slot_base[s] + $urandom_range(slot_size[s] - 1, 0);
                endcase
            end
        end else begin
            item.cmd = CMD_UNUSED;
        end
    endtask

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: response transfer with nothing outstanding: %p",
                         $time, rsp_if.data);
                fault_count++;
            end else begin
                due_answer = answers_due.pop_front();
                if (rsp_if.data.ok !== due_answer.ok) begin
                    $display("%0t: ok expected %0b got %0b",
                             $time, due_answer.ok, rsp_if.data.ok);
                    fault_count++;
                end
                if (rsp_if.data.region_base !== due_answer.region_base) begin
                    $display("%0t: region_base expected %h got %h",
                             $time, due_answer.region_base, rsp_if.data.region_base);
                    fault_count++;
                end
                if (rsp_if.data.region_size !== due_answer.region_size) begin
                    $display("%0t: region_size expected %h got %h",
                             $time, due_answer.region_size, rsp_if.data.region_size);
                    fault_count++;
                end
                if (rsp_if.data.live_entries !== due_answer.live_entries) begin
                    $display("%0t: live_entries expected %0d got %0d",
                             $time, due_answer.live_entries, rsp_if.data.live_entries);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        t_cmd_item         item;
        t_rsp_item         answer;
        t_slot_q           doomed;
        logic [ADDR_W-1:0] doomed_base [$];
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_PAD_BYTES;
        i_cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;

        pad_now = PAD_RESET;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_base[i] = '0;
            slot_size[i] = '0;
            slot_link[i] = (i + 1 < TABLE_ENTRIES) ? 7'(i + 1) : END_MARK;
        end
        slot_base[LOW_SENTINEL] = LOW_RESET;
        slot_base[HIGH_SENTINEL] = HIGH_RESET;
        slot_link[LOW_SENTINEL] = 7'(HIGH_SENTINEL);
        slot_link[HIGH_SENTINEL] = END_MARK;
        chain_head = 7'(LOW_SENTINEL);
        spare_head = 7'(FIRST_FREE);
        chain_len = 7'd2;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                wait_for_answers();
                write_register(directed_rows[r].code, directed_rows[r].value);
            end else begin
                item.cmd = directed_rows[r].code;
                item.req_size = directed_rows[r].value;
                item.addr = directed_rows[r].addr;
                answer.ok = directed_rows[r].ok;
                answer.region_base = directed_rows[r].base;
                answer.region_size = directed_rows[r].size;
                answer.live_entries = directed_rows[r].live;
                issue_command(item, directed_rows[r].typed, answer);
            end
        end

        foreach (phases[p]) begin
            wait_for_answers();
            if (phases[p].clear_first) begin
                doomed = sized_slots();
                doomed_base.delete();
                foreach (doomed[i]) begin
                    doomed_base.push_back(slot_base[doomed[i]]);
                end
                foreach (doomed_base[i]) begin
                    item.cmd = CMD_FREE;
                    item.req_size = $urandom;
                    item.addr = doomed_base[i];
                    issue_command(item, 1'b0, '0);
                end
                wait_for_answers();
            end
            write_register(CFG_PAD_BYTES, phases[p].pad_random ?
                           32'($urandom_range(32'h0010_0000, 0)) : 32'(phases[p].pad));
            write_register(CFG_REGION_LOW, phases[p].low);
            write_register(CFG_REGION_HIGH, phases[p].high);
            for (int n = 0; n < phases[p].items; n++) begin
                // Now and then the sender holds off until the list has settled.
                if ($urandom_range(99, 0) == 0) begin
                    wait_for_answers();
                end
                pick_command(phases[p].alloc_pct, phases[p].free_pct, item);
                issue_command(item, 1'b0, '0);
            end
        end

        wait_for_answers();
        repeat (250) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
